### src/mkgc_pkg.sv
// shared types and constants of the masked key group count engine
`default_nettype none
package mkgc_pkg;

  localparam int unsigned GROUP_BITS_W     = 4;
  localparam logic [3:0]  GROUP_BITS_RESET = 4'd10;

  localparam logic [1:0] MODE_COUNT = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key;
    logic [9:0]         group;
  } in_t;

  typedef struct packed {
    logic [31:0] count;
    logic [9:0]  group_index;
    logic        bad_key;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch a new beat
    logic rd;     // read the counter memory
    logic wb;     // update counter and form the result
    logic sweep;  // zero one memory entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic sweep_last;
  } sts_t;

endpackage
`default_nettype wire

### src/mkgc_ctrl.sv
// controller state machine of the masked key group count engine
`default_nettype none
module mkgc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               done_o,
  output mkgc_pkg::cmd_t     cmd_o,
  input  wire mkgc_pkg::sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       rep_q, rep_d;
  logic       done_q;
  logic       accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i & ~busy_o;

  always_comb begin
    state_d = state_q;
    rep_d   = rep_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RD;
      end
      S_RD: begin
        if (sts_i.is_clear) begin
          state_d = S_CLR;
          rep_d   = 1'b1;
        end else begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        state_d = S_IDLE;
      end
      S_CLR: begin
        // sweep after reset ends silently, a clear beat reports at the end
        if (sts_i.sweep_last) begin
          state_d = rep_q ? S_WB : S_IDLE;
          rep_d   = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.rd    = (state_q == S_RD);
    cmd_o.wb    = (state_q == S_WB);
    cmd_o.sweep = (state_q == S_CLR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      rep_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rep_q   <= rep_d;
      done_q  <= (state_q == S_WB);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

### src/mkgc_datapath.sv
// counter memory, index masking and saturating update
`default_nettype none
module mkgc_datapath #(
  parameter int unsigned MAX_GROUPS = 1024
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [3:0]     cfg_data_i,
  input  wire mkgc_pkg::in_t  req_i,
  input  wire mkgc_pkg::cmd_t cmd_i,
  output mkgc_pkg::sts_t      sts_o,
  output mkgc_pkg::out_t      res_o
);

  localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  // largest b with 2^b <= MAX_GROUPS
  localparam int unsigned IW = $clog2(MAX_GROUPS + 1) - 1;
  localparam logic [4:0]  MAXB = 5'(IW);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_GROUPS - 1);

  logic [31:0] mem [MAX_GROUPS];

  logic [3:0]    group_bits_q;
  logic [AW-1:0] sweep_q;
  logic [1:0]    mode_q;
  logic [IW-1:0] idx_q;
  logic          bad_q;
  logic [31:0]   rd_q;
  mkgc_pkg::out_t res_q;
  mkgc_pkg::out_t res_d;

  logic [4:0]    b_eff;
  logic [IW-1:0] mask;
  logic [31:0]   key_m1;
  logic [31:0]   grp_ext;
  logic [IW-1:0] idx_d;
  logic          bad_d;
  logic [31:0]   inc;
  logic [31:0]   idx_ext;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  always_comb begin
    b_eff   = ({1'b0, group_bits_q} > MAXB) ? MAXB : {1'b0, group_bits_q};
    mask    = ~({IW{1'b1}} << b_eff);
    key_m1  = req_i.key - 32'sd1;
    grp_ext = {22'd0, req_i.group};
    bad_d   = (req_i.mode == mkgc_pkg::MODE_COUNT) &&
              ((req_i.key == 32'sd0) || req_i.key[31]);
    if (req_i.mode == mkgc_pkg::MODE_COUNT) begin
      idx_d = key_m1[IW-1:0] & mask;
    end else begin
      idx_d = grp_ext[IW-1:0] & mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_bits_q <= mkgc_pkg::GROUP_BITS_RESET;
      sweep_q      <= '0;
    end else begin
      if (cfg_we_i) group_bits_q <= cfg_data_i;
      if (cmd_i.sweep) begin
        sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= req_i.mode;
      idx_q  <= idx_d;
      bad_q  <= bad_d;
    end
  end

  // saturating increment
  assign inc     = (rd_q == '1) ? rd_q : rd_q + 32'd1;
  assign idx_ext = {{(32 - IW){1'b0}}, idx_q};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(idx_q);
    wr_data = inc;
    if (cmd_i.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_q;
      wr_data = '0;
    end else if (cmd_i.wb && (mode_q == mkgc_pkg::MODE_COUNT) && !bad_q) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[AW'(idx_q)];
  end

  always_comb begin
    res_d = '0;
    case (mode_q)
      mkgc_pkg::MODE_COUNT: begin
        if (bad_q) begin
          res_d.bad_key = 1'b1;
        end else begin
          res_d.count       = inc;
          res_d.group_index = idx_ext[9:0];
        end
      end
      mkgc_pkg::MODE_READ: begin
        res_d.count       = rd_q;
        res_d.group_index = idx_ext[9:0];
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) res_q <= res_d;
  end

  assign sts_o.is_clear   = (mode_q == mkgc_pkg::MODE_CLEAR);
  assign sts_o.sweep_last = (sweep_q == LAST_ADDR);
  assign res_o            = res_q;

endmodule
`default_nettype wire

### src/masked_key_group_count_core.sv
// top level of the masked key group count engine
// A beat is taken when start_i is high and busy_o is low. Count, read and
// unused-mode beats latch and mask the index, read the counter memory, then
// update and register the result; done_o pulses for one cycle in the cycle
// after, when busy_o is already low again, so a new beat can be given then.
// A clear beat zeroes the memory one entry per cycle and then reports an
// all-zero result. After reset the same sweep runs with busy_o high and
// gives no result. The receiver cannot stall results.
// cfg_ready_o is always high; write group_bits only while idle.
`default_nettype none
module masked_key_group_count_core #(
  parameter int unsigned MAX_GROUPS = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire mkgc_pkg::in_t req_i,
  output logic               done_o,
  output mkgc_pkg::out_t     res_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [3:0]    cfg_data_i
);

  mkgc_pkg::cmd_t cmd;
  mkgc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mkgc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  mkgc_datapath #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

### src/mkgc_checker.sv
// port level checks of the masked key group count engine and their bind
`default_nettype none
module mkgc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           done_o,
  input wire mkgc_pkg::in_t  req_i,
  input wire mkgc_pkg::out_t res_o
);

  // a result only shows once the engine is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted beat");

  // every beat that is not a clear, the unused mode included, reports a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_i.mode != mkgc_pkg::MODE_CLEAR)) |-> ##3 done_o)
    else $error("result missing three cycles after beat");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.bad_key) |-> (res_o.count == 32'd0 && res_o.group_index == 10'd0))
    else $error("bad key result carries data");

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind masked_key_group_count_core mkgc_checker u_mkgc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .req_i   (req_i),
  .res_o   (res_o)
);
`default_nettype wire

### dv/masked_key_group_count_core_tb.sv
// self-checking testbench for the masked key group count engine
`timescale 1ns / 100ps
module masked_key_group_count_core_tb;

  localparam logic [1:0] MODE_NOP    = 2'd3;
  localparam int unsigned NUM_GROUPS = 1024;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned PHASE_ITEMS = 105;

  typedef enum logic [1:0] {
    BEAT_REQ,
    BEAT_CFG,
    BEAT_DRAIN
  } beat_kind_e;

  typedef struct packed {
    beat_kind_e     kind;
    logic [2:0]     gap;
    logic [3:0]     cfg;
    mkgc_pkg::in_t  req;
  } pending_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           start_i     = 1'b0;
  mkgc_pkg::in_t  req_i       = '0;
  logic           cfg_valid_i = 1'b0;
  logic [3:0]     cfg_data_i  = '0;
  logic           busy_o;
  logic           done_o;
  mkgc_pkg::out_t res_o;
  logic           cfg_ready_o;

  pending_t       pending_q[$];
  mkgc_pkg::out_t result_q[$];
  logic [31:0]    tally_mem [NUM_GROUPS];
  logic [3:0]     group_bits_mdl;
  int unsigned    mismatches = 0;
  int unsigned    idle_run = 0;
  int unsigned    stall_cycles = 0;
  int unsigned    calm_left = 0;
  pending_t       nxt;
  logic           quiet;
  mkgc_pkg::out_t exp_res;

  masked_key_group_count_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // applies one accepted beat to the counter copy and returns its result
  function automatic mkgc_pkg::out_t tally_step(mkgc_pkg::in_t req);
    mkgc_pkg::out_t r;
    logic [3:0]     b;
    logic [10:0]    mask_w;
    logic [9:0]     idx;
    logic [31:0]    k;
    r = '0;
    b = (group_bits_mdl > 4'd10) ? 4'd10 : group_bits_mdl;
    mask_w = (11'd1 << b) - 11'd1;
    k = req.key;
    case (req.mode)
      mkgc_pkg::MODE_COUNT: begin
        if (k == 32'd0 || k[31]) begin
          r.bad_key = 1'b1;
        end else begin
          idx = (k[9:0] - 10'd1) & mask_w[9:0];
          if (tally_mem[idx] != 32'hFFFF_FFFF) tally_mem[idx] = tally_mem[idx] + 32'd1;
          r.count = tally_mem[idx];
          r.group_index = idx;
        end
      end
      mkgc_pkg::MODE_READ: begin
        idx = req.group & mask_w[9:0];
        r.count = tally_mem[idx];
        r.group_index = idx;
      end
      mkgc_pkg::MODE_CLEAR: begin
        foreach (tally_mem[i]) tally_mem[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_req(input logic [1:0] mode, input logic [31:0] key,
                          input logic [9:0] group);
    pending_t p;
    p = '0;
    p.kind = BEAT_REQ;
    p.req.mode = mode;
    p.req.key = key;
    p.req.group = group;
    // stretches of back-to-back beats between randomly spaced ones
    if (calm_left > 0) begin
      calm_left--;
      p.gap = 3'd0;
    end else begin
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 30);
      p.gap = 3'($urandom_range(0, 6));
    end
    pending_q.push_back(p);
  endtask

  task automatic push_ctrl(input beat_kind_e kind, input logic [3:0] value);
    pending_t p;
    p = '0;
    p.kind = kind;
    p.cfg = value;
    pending_q.push_back(p);
  endtask

  task automatic push_random_req();
    int unsigned pick;
    logic [31:0] noise;
    logic [31:0] k;
    logic [9:0]  g;
    pick = $urandom_range(0, 99);
    noise = $urandom();
    g = 10'($urandom());
    if (pick < 45) begin
      push_req(mkgc_pkg::MODE_COUNT, $urandom_range(1, 2048), g);
    end else if (pick < 55) begin
      k = {1'b0, noise[30:0]};
      if (k == 32'd0) k = 32'd1;
      push_req(mkgc_pkg::MODE_COUNT, k, g);
    end else if (pick < 62) begin
      k = ($urandom_range(0, 3) == 0) ? 32'd0 : {1'b1, noise[30:0]};
      push_req(mkgc_pkg::MODE_COUNT, k, g);
    end else if (pick < 91) begin
      push_req(mkgc_pkg::MODE_READ, noise, g);
    end else if (pick < 95) begin
      push_req(MODE_NOP, noise, g);
    end else if (pick < 97) begin
      push_req(mkgc_pkg::MODE_CLEAR, noise, g);
    end else begin
      // hammer one counter
      push_req(mkgc_pkg::MODE_COUNT, 32'd1, g);
    end
  endtask

  // driver: one beat per queue entry, gap counted from the previous acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_data_i <= '0;
      idle_run <= 0;
    end else begin
      if (start_i && !busy_o) result_q.push_back(tally_step(req_i));
      if (cfg_valid_i && cfg_ready_o) group_bits_mdl = cfg_data_i;
      if ((start_i && busy_o) || (cfg_valid_i && !cfg_ready_o)) begin
        // beat still waiting to be taken
      end else if (pending_q.size() == 0) begin
        start_i <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else begin
        nxt = pending_q[0];
        quiet = (result_q.size() == 0) && !busy_o && !start_i;
        if (nxt.kind == BEAT_REQ && idle_run >= nxt.gap) begin
          start_i <= 1'b1;
          req_i <= nxt.req;
          cfg_valid_i <= 1'b0;
          idle_run <= 0;
          void'(pending_q.pop_front());
        end else if (nxt.kind == BEAT_CFG && quiet) begin
          start_i <= 1'b0;
          cfg_valid_i <= 1'b1;
          cfg_data_i <= nxt.cfg;
          idle_run <= 0;
          void'(pending_q.pop_front());
        end else begin
          start_i <= 1'b0;
          cfg_valid_i <= 1'b0;
          idle_run <= idle_run + 1;
          if (nxt.kind == BEAT_DRAIN && quiet) void'(pending_q.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result count %h group %h bad %b", $time,
                 res_o.count, res_o.group_index, res_o.bad_key);
        mismatches++;
      end else begin
        exp_res = result_q.pop_front();
        if (res_o.count !== exp_res.count) begin
          $display("%0t: count expected %h got %h", $time, exp_res.count, res_o.count);
          mismatches++;
        end
        if (res_o.group_index !== exp_res.group_index) begin
          $display("%0t: group_index expected %h got %h", $time,
                   exp_res.group_index, res_o.group_index);
          mismatches++;
        end
        if (res_o.bad_key !== exp_res.bad_key) begin
          $display("%0t: bad_key expected %b got %b", $time, exp_res.bad_key, res_o.bad_key);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on any port
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (tally_mem[i]) tally_mem[i] = '0;
    group_bits_mdl = mkgc_pkg::GROUP_BITS_RESET;

    // full table after reset
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd0);
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd1023);
    push_req(mkgc_pkg::MODE_COUNT, 32'd1, 10'd1023);
    push_req(mkgc_pkg::MODE_COUNT, 32'd1, 10'd0);
    push_req(mkgc_pkg::MODE_COUNT, 32'd1024, $urandom());
    push_req(mkgc_pkg::MODE_COUNT, 32'd1025, $urandom());
    push_req(mkgc_pkg::MODE_COUNT, 32'h7FFF_FFFF, 10'd1023);
    push_req(mkgc_pkg::MODE_COUNT, 32'd0, 10'd5);
    push_req(mkgc_pkg::MODE_COUNT, 32'hFFFF_FFFF, 10'd1023);
    push_req(mkgc_pkg::MODE_COUNT, 32'h8000_0000, 10'd0);
    push_req(mkgc_pkg::MODE_READ, 32'h8000_0000, 10'd1023);
    push_req(mkgc_pkg::MODE_READ, 32'hFFFF_FFFF, 10'd0);
    push_req(MODE_NOP, 32'd1, 10'd0);
    push_req(mkgc_pkg::MODE_READ, 32'd0, 10'd0);
    push_req(mkgc_pkg::MODE_CLEAR, 32'd1, 10'd1023);
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd0);
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd1022);
    push_req(mkgc_pkg::MODE_COUNT, 32'd2, 10'd1023);
    // single group: every key and read lands on counter zero
    push_ctrl(BEAT_CFG, 4'd0);
    push_req(mkgc_pkg::MODE_COUNT, 32'd7, 10'd3);
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd1023);
    push_req(mkgc_pkg::MODE_COUNT, 32'h7FFF_FFFF, 10'd0);
    // oversized setting falls back to the full table, counters kept
    push_ctrl(BEAT_CFG, 4'd15);
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd1);
    push_req(mkgc_pkg::MODE_COUNT, 32'd1025, $urandom());
    push_req(mkgc_pkg::MODE_READ, $urandom(), 10'd1023);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: push_ctrl(BEAT_CFG, 4'd0);
        1: push_ctrl(BEAT_CFG, 4'd15);
        2: push_ctrl(BEAT_CFG, 4'd1);
        3: push_ctrl(BEAT_CFG, 4'd10);
        4: push_ctrl(BEAT_CFG, 4'd4);
        5: push_ctrl(BEAT_CFG, 4'd11);
        default: push_ctrl(BEAT_CFG, 4'($urandom_range(0, 15)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph[0]) push_ctrl(BEAT_DRAIN, 4'd0);
        push_random_req();
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || start_i || cfg_valid_i || result_q.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
